>>> rtl/rsm_pkg.sv
`timescale 1ns / 1ps
// Package for row_softmax: widths, row-store depth, phase enum and the
// 2^(-f/256) fraction table. Used by all rtl modules.
package rsm_pkg;
	localparam int MaxColumns = 64;
	localparam int ValueWidth = 16;
	localparam int AddrWidth = $clog2(MaxColumns);
	localparam int CountWidth = $clog2(MaxColumns + 1);
	localparam int ProbWidth = 16;
	localparam int SumWidth = 23;
	localparam int DiffWidth = ValueWidth + 1;
	localparam int ProdWidth = DiffWidth + 9;
	localparam logic [8:0] Log2eQ8 = 9'd369;

	typedef enum logic [2:0] {
		PH_LOAD,
		PH_EXP_RD,
		PH_EXP_MUL,
		PH_EXP_WR,
		PH_DIV_RD,
		PH_DIV_RUN,
		PH_OUT
	} phase_t;

	typedef struct packed {
		logic start;
		logic [ProbWidth-1:0] num;
		logic [SumWidth-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [ProbWidth-1:0] quo;
	} div_rsp_t;

	// 256 x 16 table of 2^(-f/256) in Q0.16, entry f at bits [16*f +: 16]
	function automatic logic [256*16-1:0] build_frac_table();
		logic [64:0] r;
		logic [64:0] q;
		logic [256*16-1:0] tbl;
		r = 65'd1 << 32;
		tbl = '0;
		for (int k = 0; k < 256; k++) begin
			q = (r + 65'd32768) >> 16;
			tbl[k*16 +: 16] = (q > 65'd65535) ? 16'hFFFF : q[15:0];
			r = (r * 65'd4283353945 + (65'd1 << 31)) >> 32;
		end
		return tbl;
	endfunction

	localparam logic [256*16-1:0] FracTable = build_frac_table();
endpackage

>>> rtl/rsm_divider.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: (num << 16) / den, one quotient bit per cycle,
// saturated to 16 bits. Depends on rsm_pkg.
module rsm_divider (
	input logic clk,
	input logic arst_n,
	input rsm_pkg::div_req_t req,
	output rsm_pkg::div_rsp_t rsp
);
	localparam int QBits = 2 * rsm_pkg::ProbWidth;
	logic [QBits-1:0] dvd_q;
	logic [rsm_pkg::SumWidth:0] rem_q;
	logic [rsm_pkg::SumWidth-1:0] den_q;
	logic [5:0] cnt_q;
	logic busy_q, done_q;
	logic [rsm_pkg::SumWidth:0] trial;
	logic fits;

	assign trial = {rem_q[rsm_pkg::SumWidth-1:0], dvd_q[QBits-1]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(QBits);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= {req.num, 16'h0};
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			// shift quotient bits into the freed low end of the dividend
			dvd_q <= {dvd_q[QBits-2:0], fits};
			rem_q <= fits ? trial - {1'b0, den_q} : trial;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo = (den_q == '0) ? '0 :
		((dvd_q[QBits-1:16] != '0) ? 16'hFFFF : dvd_q[15:0]);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> $past(busy_q)) else $error("done without busy");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("start while busy");
	a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> cnt_q == 6'd0 || req.start == 1'b0) else $error("counter");
endmodule

>>> rtl/row_softmax.sv
`timescale 1ns / 1ps
// row_softmax: loads one element per cycle while in the load phase and valid_in is high.
// After the last beat, each element's exponent takes a memory read, a multiply and a write;
// then each element takes a memory read, a divider start, the bit-serial division, the
// divider's done strobe and an output beat.
// In emit, each division must finish before the next one starts, so the divider paces results.
// arst_n clears count, max, sum, error flag and the phase; memories are not cleared.
module row_softmax (
	input logic clk,
	input logic arst_n,
	input logic valid_in,
	output logic ready_in,
	input logic [15:0] value_in,
	input logic last_in,
	output logic valid_out,
	input logic ready_out,
	output logic [15:0] prob_out,
	output logic last_out,
	output logic row_error
);
	localparam int AW = rsm_pkg::AddrWidth;
	localparam int CW = rsm_pkg::CountWidth;

	rsm_pkg::phase_t ph_q, ph_d;
	logic [15:0] row_mem [rsm_pkg::MaxColumns];
	logic [15:0] exp_mem [rsm_pkg::MaxColumns];
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] idx_q;
	logic signed [15:0] max_q;
	logic [rsm_pkg::SumWidth-1:0] sum_q;
	logic err_q;
	logic [15:0] rd_q, exp_rd_q;
	logic [rsm_pkg::ProdWidth-1:0] prod_q;
	logic [15:0] expv;
	logic [15:0] prob_q;
	logic accept, is_last_idx, store_ok;
	logic [rsm_pkg::DiffWidth-1:0] diff;
	logic [rsm_pkg::ProdWidth-9:0] u;
	rsm_pkg::div_req_t dreq;
	rsm_pkg::div_rsp_t drsp;

	assign accept = valid_in && ready_in;
	assign ready_in = (ph_q == rsm_pkg::PH_LOAD);
	assign store_ok = cnt_q < CW'(rsm_pkg::MaxColumns);
	assign is_last_idx = ({1'b0, idx_q} == cnt_q - CW'(1));
	assign diff = {max_q[15], max_q} - {rd_q[15], rd_q};
	assign u = prod_q[rsm_pkg::ProdWidth-1:8];
	assign expv = (u[rsm_pkg::ProdWidth-9:8] >= 16) ? 16'h0 :
		(rsm_pkg::FracTable[{u[7:0], 4'b0000} +: 16] >> u[11:8]);
	assign valid_out = (ph_q == rsm_pkg::PH_OUT);
	assign prob_out = prob_q;
	assign last_out = is_last_idx;
	assign row_error = err_q;
	// start on the first run cycle, once the numerator read has landed
	assign dreq.start = (ph_q == rsm_pkg::PH_DIV_RUN) && !drsp.busy && !drsp.done;
	assign dreq.num = exp_rd_q;
	assign dreq.den = sum_q;

	always_comb begin
		ph_d = ph_q;
		unique case (ph_q)
			rsm_pkg::PH_LOAD: if (accept && last_in) ph_d = rsm_pkg::PH_EXP_RD;
			rsm_pkg::PH_EXP_RD: ph_d = rsm_pkg::PH_EXP_MUL;
			rsm_pkg::PH_EXP_MUL: ph_d = rsm_pkg::PH_EXP_WR;
			rsm_pkg::PH_EXP_WR: ph_d = is_last_idx ? rsm_pkg::PH_DIV_RD :
				rsm_pkg::PH_EXP_RD;
			rsm_pkg::PH_DIV_RD: ph_d = rsm_pkg::PH_DIV_RUN;
			rsm_pkg::PH_DIV_RUN: if (drsp.done) ph_d = rsm_pkg::PH_OUT;
			rsm_pkg::PH_OUT: if (ready_out)
				ph_d = is_last_idx ? rsm_pkg::PH_LOAD : rsm_pkg::PH_DIV_RD;
			default: ph_d = rsm_pkg::PH_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= rsm_pkg::PH_LOAD;
			cnt_q <= '0;
			idx_q <= '0;
			max_q <= 16'sh8000;
			sum_q <= '0;
			err_q <= 1'b0;
		end else begin
			ph_q <= ph_d;
			unique case (ph_q)
				rsm_pkg::PH_LOAD: if (accept) begin
					if (store_ok) begin
						if (cnt_q == '0 || $signed(value_in) > max_q) max_q <= value_in;
						cnt_q <= cnt_q + CW'(1);
					end else begin
						err_q <= 1'b1;
					end
					idx_q <= '0;
					sum_q <= '0;
				end
				rsm_pkg::PH_EXP_WR: begin
					sum_q <= sum_q + rsm_pkg::SumWidth'(expv);
					idx_q <= is_last_idx ? '0 : idx_q + AW'(1);
				end
				rsm_pkg::PH_OUT: if (ready_out) begin
					if (is_last_idx) begin
						cnt_q <= '0;
						max_q <= 16'sh8000;
						sum_q <= '0;
						err_q <= 1'b0;
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && store_ok) row_mem[cnt_q[AW-1:0]] <= value_in;
		rd_q <= row_mem[idx_q];
		exp_rd_q <= exp_mem[idx_q];
		if (ph_q == rsm_pkg::PH_EXP_MUL)
			prod_q <= rsm_pkg::ProdWidth'(diff) * rsm_pkg::Log2eQ8;
		if (ph_q == rsm_pkg::PH_EXP_WR) exp_mem[idx_q] <= expv;
		if (drsp.done) prob_q <= drsp.quo;
	end

	rsm_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	a_no_out_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out |-> !ready_in) else $error("overlap");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(rsm_pkg::MaxColumns)) else $error("count range");
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out |-> cnt_q != '0) else $error("empty row emit");
endmodule
